[rtl/touch_gesture_tracker_core_macros.svh]
// Assertion macros shared by the touch gesture tracker RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef TOUCH_GESTURE_TRACKER_CORE_MACROS_SVH
`define TOUCH_GESTURE_TRACKER_CORE_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define TGT_ASSERT_SAME(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("touch gesture tracker assertion failed");

// Condition a implies condition c in the next cycle.
`define TGT_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("touch gesture tracker assertion failed");

`endif

[rtl/tgt_pkg.sv]
// Types, codes and reset values for the touch gesture tracker.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package tgt_pkg;

	typedef struct packed {
		logic [15:0] width;
		logic [15:0] height;
		logic [14:0] threshold;
		logic        portrait;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  touch_count;
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [1:0]  touch_event;
	} item_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
	} point_t;

	typedef struct packed {
		logic [2:0]         gesture;
		logic [15:0]        pos_x;
		logic [15:0]        pos_y;
		logic [15:0]        start_x;
		logic [15:0]        start_y;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
	} result_t;

	typedef enum logic [4:0] {
		ST_NONE      = 5'b00001,
		ST_DOWN      = 5'b00010,
		ST_UP        = 5'b00100,
		ST_SLIDE     = 5'b01000,
		ST_SLIDE_END = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_PORTRAIT  = 2'd3
	} reg_index_t;

	localparam logic [2:0] GEST_NONE      = 3'd0;
	localparam logic [2:0] GEST_DOWN      = 3'd1;
	localparam logic [2:0] GEST_UP        = 3'd2;
	localparam logic [2:0] GEST_SLIDE     = 3'd3;
	localparam logic [2:0] GEST_SLIDE_END = 3'd4;

	localparam logic [1:0] EV_CONTACT = 2'd2;
	localparam logic [3:0] MAX_TOUCHES = 4'd2;

	localparam logic [15:0] WIDTH_RESET     = 16'd320;
	localparam logic [15:0] HEIGHT_RESET    = 16'd480;
	localparam logic [14:0] THRESHOLD_RESET = 15'd10;

	function automatic logic [2:0] gesture_code(state_t s);
		logic [2:0] code;
		unique case (s)
			ST_NONE:      code = GEST_NONE;
			ST_DOWN:      code = GEST_DOWN;
			ST_UP:        code = GEST_UP;
			ST_SLIDE:     code = GEST_SLIDE;
			ST_SLIDE_END: code = GEST_SLIDE_END;
			default:      code = GEST_NONE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

[rtl/tgt_cfg_regs.sv]
// APB register file for screen size, slide threshold and orientation.
// Depends on tgt_pkg.
`default_nettype none

module tgt_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output tgt_pkg::cfg_t    cfg
);
	import tgt_pkg::*;

	reg_index_t idx;
	logic       wr_en;

	assign idx    = reg_index_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.width     <= WIDTH_RESET;
			cfg.height    <= HEIGHT_RESET;
			cfg.threshold <= THRESHOLD_RESET;
			cfg.portrait  <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_WIDTH:     cfg.width     <= pwdata[15:0];
				REG_HEIGHT:    cfg.height    <= pwdata[15:0];
				REG_THRESHOLD: cfg.threshold <= pwdata[14:0];
				REG_PORTRAIT:  cfg.portrait  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:     prdata = {16'd0, cfg.width};
			REG_HEIGHT:    prdata = {16'd0, cfg.height};
			REG_THRESHOLD: prdata = {17'd0, cfg.threshold};
			REG_PORTRAIT:  prdata = {31'd0, cfg.portrait};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/tgt_rotate.sv]
// Maps a raw panel point to screen coordinates for the selected orientation.
// Depends on tgt_pkg.
`default_nettype none

module tgt_rotate (
	input  wire logic [11:0]   raw_x,
	input  wire logic [11:0]   raw_y,
	input  tgt_pkg::cfg_t      cfg,
	output tgt_pkg::point_t    pt
);
	import tgt_pkg::*;

	// Portrait mirrors both axes; landscape swaps them and mirrors x. All math wraps at 16 bits.
	always_comb begin
		if (cfg.portrait) begin
			pt.x = cfg.width - {4'd0, raw_x};
			pt.y = cfg.height - {4'd0, raw_y};
		end else begin
			pt.x = cfg.width - 16'd1 - {4'd0, raw_y};
			pt.y = {4'd0, raw_x};
		end
	end

endmodule

`default_nettype wire

[rtl/tgt_tracker.sv]
// Gesture state machine with position, start point and movement registers.
// Depends on tgt_pkg, tgt_rotate and the assertion macro header; the registers also form the result.
`default_nettype none

`include "touch_gesture_tracker_core_macros.svh"

module tgt_tracker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  tgt_pkg::item_t     item,
	input  tgt_pkg::cfg_t      cfg,
	output tgt_pkg::result_t   res
);
	import tgt_pkg::*;

	state_t state_q, state_d;
	logic [15:0] last_x_q, last_y_q, last_x_d, last_y_d;
	logic [15:0] origin_x_q, origin_y_q, origin_x_d, origin_y_d;
	logic [15:0] move_x_q, move_y_q, move_x_d, move_y_d;

	point_t             pt;
	logic               no_touch;
	logic signed [16:0] dx, dy, th, neg_th;
	logic               beyond;

	tgt_rotate u_rotate (
		.raw_x (item.raw_x),
		.raw_y (item.raw_y),
		.cfg   (cfg),
		.pt    (pt)
	);

	assign no_touch = (item.touch_count == 4'd0) || (item.touch_count > MAX_TOUCHES);
	assign dx       = $signed({1'b0, pt.x}) - $signed({1'b0, last_x_q});
	assign dy       = $signed({1'b0, pt.y}) - $signed({1'b0, last_y_q});
	assign th       = $signed({2'b00, cfg.threshold});
	assign neg_th   = -th;
	assign beyond   = (dx >= th) || (dx <= neg_th) || (dy >= th) || (dy <= neg_th);

	always_comb begin
		state_d    = state_q;
		last_x_d   = last_x_q;
		last_y_d   = last_y_q;
		origin_x_d = origin_x_q;
		origin_y_d = origin_y_q;
		move_x_d   = move_x_q;
		move_y_d   = move_y_q;
		if (no_touch) begin
			if (state_q == ST_DOWN) begin
				state_d = ST_UP;
			end else begin
				last_x_d = cfg.width;
				last_y_d = cfg.height;
				state_d  = ST_SLIDE_END;
			end
		end else if (item.touch_event == EV_CONTACT) begin
			last_x_d = pt.x;
			last_y_d = pt.y;
			unique case (state_q) inside
				ST_NONE, ST_UP: begin
					origin_x_d = pt.x;
					origin_y_d = pt.y;
					state_d    = ST_DOWN;
				end
				ST_DOWN: begin
					if (beyond) begin
						state_d  = ST_SLIDE;
						move_x_d = dx[15:0];
						move_y_d = dy[15:0];
					end else begin
						move_x_d = 16'd0;
						move_y_d = 16'd0;
					end
				end
				ST_SLIDE: begin
					move_x_d = dx[15:0];
					move_y_d = dy[15:0];
				end
				ST_SLIDE_END: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_NONE;
			last_x_q   <= 16'd0;
			last_y_q   <= 16'd0;
			origin_x_q <= 16'd0;
			origin_y_q <= 16'd0;
			move_x_q   <= 16'd0;
			move_y_q   <= 16'd0;
		end else if (en) begin
			state_q    <= state_d;
			last_x_q   <= last_x_d;
			last_y_q   <= last_y_d;
			origin_x_q <= origin_x_d;
			origin_y_q <= origin_y_d;
			move_x_q   <= move_x_d;
			move_y_q   <= move_y_d;
		end
	end

	assign res.gesture = gesture_code(state_q);
	assign res.pos_x   = last_x_q;
	assign res.pos_y   = last_y_q;
	assign res.start_x = origin_x_q;
	assign res.start_y = origin_y_q;
	assign res.delta_x = $signed(move_x_q);
	assign res.delta_y = $signed(move_y_q);

	`TGT_ASSERT_NEXT(a_release_goes_up, en && no_touch && (state_q == ST_DOWN),
		(state_q == ST_UP) && $stable(last_x_q) && $stable(last_y_q))
	`TGT_ASSERT_NEXT(a_press_sets_start, en && !no_touch &&
		(item.touch_event == EV_CONTACT) && ((state_q == ST_NONE) || (state_q == ST_UP)),
		(state_q == ST_DOWN) && (origin_x_q == last_x_q) && (origin_y_q == last_y_q))
	`TGT_ASSERT_NEXT(a_idle_holds, !en, $stable(state_q) && $stable(last_x_q) &&
		$stable(move_x_q))

endmodule

`default_nettype wire

[rtl/touch_gesture_tracker_core.sv]
// Top level of the touch gesture tracker: stream ports, input stage, flow control.
// Depends on tgt_pkg, tgt_cfg_regs, tgt_tracker and the assertion macro header.
//
// Channel   Direction  Carries
// s_*       in         one panel report per request (count, raw point, event)
// m_*       out        one gesture result per report (state, position, start, delta)
// APB       in/out     screen width, screen height, slide threshold, portrait mode
//
// One report per cycle is sustained while m_tready does not stall the result.
// The report is registered, then rotation, delta and threshold logic update the
// state registers, which also hold the result shown on m_tdata and m_tuser.
// A stalled result holds the state; the input stage fills and then s_tready drops.
// Reset clears the state to none with zero coordinates and loads default settings.
`default_nettype none

`include "touch_gesture_tracker_core_macros.svh"

module touch_gesture_tracker_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // touch_count[3:0], raw_x[15:4], raw_y[27:16], zero
	input  wire logic [1:0]  s_tuser,  // touch_event[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [95:0] m_tdata,  // pos_x, pos_y, start_x, start_y, delta_x, delta_y
	output logic      [2:0]  m_tuser,  // gesture[2:0]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import tgt_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;

	tgt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.touch_count <= s_tdata[3:0];
			item_s1.raw_x       <= s_tdata[15:4];
			item_s1.raw_y       <= s_tdata[27:16];
			item_s1.touch_event <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	tgt_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tuser = res.gesture;
	assign m_tdata = {res.delta_y, res.delta_x, res.start_y, res.start_x, res.pos_y, res.pos_x};

	`TGT_ASSERT_SAME(a_stall_means_full, !s_tready, valid_s1 && m_tvalid)
	`TGT_ASSERT_NEXT(a_accept_fills_stage, s_tvalid && s_tready, valid_s1)
	`TGT_ASSERT_NEXT(a_advance_shows_result, advance, m_tvalid)

endmodule

`default_nettype wire

[sim/touch_gesture_tracker_core_test.sv]
// Self-checking testbench for touch_gesture_tracker_core: panel reports in, gesture results out.
// Predicts each result in a local gesture tracker and checks it field by field.
// Depends on tgt_pkg and the touch_gesture_tracker_core RTL.

module touch_gesture_tracker_core_test;
	import tgt_pkg::*;

	localparam logic [1:0] EV_PRESS = 2'd0;
	localparam logic [1:0] EV_LIFT = 2'd1;
	localparam logic [1:0] EV_NONE = 2'd3;

	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_PRINTED = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [2:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	cfg_t settings = '{width: WIDTH_RESET, height: HEIGHT_RESET,
		threshold: THRESHOLD_RESET, portrait: 1'b0};
	result_t tracker = '0;
	result_t planned = '0;
	item_t pending_reports[$];
	result_t expected_results[$];
	item_t offered = '0;
	bit offer_live = 1'b0;
	int send_idle_pct = 25;
	int recv_idle_pct = 88;
	int mismatches = 0;
	int results_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [11:0] last_raw_x = '0;
	logic [11:0] last_raw_y = '0;

	touch_gesture_tracker_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t next_gesture(result_t st, cfg_t cfg, item_t rep);
		result_t nxt;
		logic [15:0] nx;
		logic [15:0] ny;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [16:0] th;
		nxt = st;
		if (rep.touch_count == 4'd0 || rep.touch_count > MAX_TOUCHES) begin
			if (st.gesture == GEST_DOWN) begin
				nxt.gesture = GEST_UP;
			end else begin
				nxt.pos_x = cfg.width;
				nxt.pos_y = cfg.height;
				nxt.gesture = GEST_SLIDE_END;
			end
		end else if (rep.touch_event == EV_CONTACT) begin
			if (cfg.portrait) begin
				nx = cfg.width - 16'(rep.raw_x);
				ny = cfg.height - 16'(rep.raw_y);
			end else begin
				nx = cfg.width - 16'd1 - 16'(rep.raw_y);
				ny = 16'(rep.raw_x);
			end
			dx = $signed({1'b0, nx}) - $signed({1'b0, st.pos_x});
			dy = $signed({1'b0, ny}) - $signed({1'b0, st.pos_y});
			th = $signed({2'b00, cfg.threshold});
			nxt.pos_x = nx;
			nxt.pos_y = ny;
			case (st.gesture)
				GEST_NONE, GEST_UP: begin
					nxt.start_x = nx;
					nxt.start_y = ny;
					nxt.gesture = GEST_DOWN;
				end
				GEST_DOWN: begin
					if (dx >= th || dx <= -th || dy >= th || dy <= -th) begin
						nxt.gesture = GEST_SLIDE;
						nxt.delta_x = dx[15:0];
						nxt.delta_y = dy[15:0];
					end else begin
						nxt.delta_x = '0;
						nxt.delta_y = '0;
					end
				end
				GEST_SLIDE: begin
					nxt.delta_x = dx[15:0];
					nxt.delta_y = dy[15:0];
				end
				default: begin
				end
			endcase
		end
		return nxt;
	endfunction

	function automatic item_t draw_report();
		item_t r;
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			r.touch_count = 4'd0;
		else if (pick == 1)
			r.touch_count = 4'($urandom_range(15, 3));
		else
			r.touch_count = 4'($urandom_range(2, 1));
		r.touch_event = ($urandom_range(3) != 0) ? EV_CONTACT : 2'($urandom_range(3));
		pick = $urandom_range(5);
		if (pick < 2) begin
			r.raw_x = last_raw_x + 12'($urandom_range(6)) - 12'd3;
			r.raw_y = last_raw_y + 12'($urandom_range(6)) - 12'd3;
		end else if (pick == 2) begin
			r.raw_x = $urandom_range(1) ? 12'hfff : 12'h000;
			r.raw_y = $urandom_range(1) ? 12'hfff : 12'h000;
		end else begin
			r.raw_x = 12'($urandom_range(4095));
			r.raw_y = 12'($urandom_range(4095));
		end
		last_raw_x = r.raw_x;
		last_raw_y = r.raw_y;
		return r;
	endfunction

	task automatic queue_report(logic [3:0] count, logic [11:0] rx, logic [11:0] ry,
			logic [1:0] ev);
		item_t r;
		r = '{touch_count: count, raw_x: rx, raw_y: ry, touch_event: ev};
		planned = next_gesture(planned, settings, r);
		pending_reports.push_back(r);
	endtask

	// The slide end state is never left, so a phase may forbid the draws that would
	// reach slide or slide end and keep the earlier states busy.
	task automatic queue_random_reports(int count, bit slide_ok, bit end_ok);
		item_t r;
		result_t trial;
		int n;
		n = 0;
		while (n < count) begin
			r = draw_report();
			trial = next_gesture(planned, settings, r);
			if ((trial.gesture == GEST_SLIDE && !slide_ok) ||
					(trial.gesture == GEST_SLIDE_END && !end_ok))
				continue;
			planned = trial;
			pending_reports.push_back(r);
			n++;
		end
	endtask

	task automatic write_setting(reg_index_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH: settings.width = value[15:0];
			REG_HEIGHT: settings.height = value[15:0];
			REG_THRESHOLD: settings.threshold = value[14:0];
			REG_PORTRAIT: settings.portrait = value[0];
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reports.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic run_phase(int w, int h, int th, bit portrait, int send_pct, int recv_pct,
			int count, bit slide_ok, bit end_ok);
		wait_idle();
		write_setting(REG_WIDTH, w);
		write_setting(REG_HEIGHT, h);
		write_setting(REG_THRESHOLD, th);
		write_setting(REG_PORTRAIT, 32'(portrait));
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
		@(negedge clk);
		queue_random_reports(count, slide_ok, end_ok);
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("result %0d: %s", results_seen, msg);
	endtask

	always @(posedge clk) begin : driver
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tracker = next_gesture(tracker, settings, offered);
				expected_results.push_back(tracker);
				offer_live = 1'b0;
			end
			if (!offer_live && pending_reports.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				offered = pending_reports.pop_front();
				offer_live = 1'b1;
			end
			s_tvalid <= offer_live;
			s_tdata <= {4'b0000, offered.raw_y, offered.raw_x, offered.touch_count};
			s_tuser <= offered.touch_event;
		end
	end

	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		bit ready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.gesture = m_tuser;
				got.pos_x = m_tdata[15:0];
				got.pos_y = m_tdata[31:16];
				got.start_x = m_tdata[47:32];
				got.start_y = m_tdata[63:48];
				got.delta_x = m_tdata[79:64];
				got.delta_y = m_tdata[95:80];
				if (expected_results.size() == 0) begin
					report_mismatch("result arrived with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (got.gesture !== want.gesture)
						report_mismatch($sformatf("gesture %0d, expected %0d",
							got.gesture, want.gesture));
					if (got.pos_x !== want.pos_x)
						report_mismatch($sformatf("pos_x %0d, expected %0d",
							got.pos_x, want.pos_x));
					if (got.pos_y !== want.pos_y)
						report_mismatch($sformatf("pos_y %0d, expected %0d",
							got.pos_y, want.pos_y));
					if (got.start_x !== want.start_x)
						report_mismatch($sformatf("start_x %0d, expected %0d",
							got.start_x, want.start_x));
					if (got.start_y !== want.start_y)
						report_mismatch($sformatf("start_y %0d, expected %0d",
							got.start_y, want.start_y));
					if (got.delta_x !== want.delta_x)
						report_mismatch($sformatf("delta_x %0d, expected %0d",
							got.delta_x, want.delta_x));
					if (got.delta_y !== want.delta_y)
						report_mismatch($sformatf("delta_y %0d, expected %0d",
							got.delta_y, want.delta_y));
				end
				results_seen++;
				if (results_seen == HOLD_AT_RESULT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready = 1'b0;
			end else begin
				ready = $urandom_range(99) >= recv_idle_pct;
			end
			m_tready <= ready;
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Default landscape screen: reports that carry a touch but no contact change
		// nothing, then presses and lifts stay below the slide threshold.
		queue_report(4'd1, 12'd0, 12'd0, EV_PRESS);
		queue_report(4'd2, 12'hfff, 12'hfff, EV_LIFT);
		queue_report(4'd1, 12'hfff, 12'd0, EV_NONE);
		queue_report(4'd1, 12'd0, 12'd0, EV_CONTACT);
		queue_report(4'd2, 12'd5, 12'd3, EV_CONTACT);
		queue_report(4'd1, 12'd14, 12'd0, EV_CONTACT);
		queue_report(4'd0, 12'd0, 12'd0, EV_CONTACT);
		queue_report(4'd1, 12'hfff, 12'd319, EV_CONTACT);
		queue_report(4'd2, 12'hfff, 12'd319, EV_PRESS);
		queue_report(4'd1, 12'hfff, 12'd310, EV_CONTACT);
		queue_report(4'd15, 12'hfff, 12'hfff, EV_CONTACT);
		queue_report(4'd2, 12'd100, 12'd200, EV_CONTACT);
		queue_report(4'd3, 12'd0, 12'd0, EV_LIFT);
		queue_report(4'd1, 12'hfff, 12'hfff, EV_CONTACT);
		queue_report(4'd8, 12'd0, 12'd0, EV_NONE);
		queue_report(4'd1, 12'd0, 12'd0, EV_CONTACT);

		run_phase(65535, 65535, 32767, 1'b1, 25, 88, 450, 1'b0, 1'b0);
		run_phase(1, 1, 32767, 1'b0, 88, 25, 450, 1'b0, 1'b0);
		run_phase(800, 600, 1, 1'b1, 0, 0, 400, 1'b1, 1'b0);
		run_phase(320, 480, 10, 1'b0, 0, 0, 350, 1'b1, 1'b1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
